// File: hdl/prt_pkg.sv
// prt_pkg: shared types and codes for the page region table
// table entry layout, command codes, status codes and config indices; no dependencies
`default_nettype none
package prt_pkg;

  localparam int PAGE_W = 21;
  localparam int OFF_W  = 20;

  typedef struct packed {
    logic [PAGE_W-1:0] start_pg;
    logic [PAGE_W-1:0] end_pg;
    logic [OFF_W-1:0]  offset;
    logic [2:0]        prot;
    logic              shared;
  } entry_t;

  localparam logic [2:0] CMD_MAP    = 3'd0;
  localparam logic [2:0] CMD_UNMAP  = 3'd1;
  localparam logic [2:0] CMD_LOOKUP = 3'd2;
  localparam logic [2:0] CMD_FIND   = 3'd3;
  localparam logic [2:0] CMD_EMPTY  = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NO_FOUND = 2'd3;

  localparam logic CFG_LOW  = 1'b0;
  localparam logic CFG_HIGH = 1'b1;

endpackage
`default_nettype wire

// File: hdl/prt_store.sv
// prt_store: two-bank entry memory, one write and one registered read per cycle
// depends on prt_pkg for the entry layout
`default_nettype none
module prt_store
  import prt_pkg::*;
#(
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: hdl/page_region_table.sv
// page_region_table: sorted table of page regions with map, unmap, lookup,
// first-fit search, empty test and clear; uses prt_pkg and prt_store
// each entry scanned is read, then evaluated; map and unmap rebuild the table
// into the other bank, writing each kept piece and the new region in order;
// a map by search scans first; one request at a time, set by the
// shared compare/add unit and memory port; reset clears region count and bank
`default_nettype none
module page_region_table
  import prt_pkg::*;
#(
  parameter int MAX_REGIONS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [20:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  cmd,
  input  wire logic [20:0] first_page,
  input  wire logic [20:0] page_count,
  input  wire logic        direction,
  input  wire logic [2:0]  protection,
  input  wire logic        shared,
  input  wire logic [19:0] offset_page,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       status,
  output logic [20:0]      result_page,
  output logic [20:0]      region_end,
  output logic [19:0]      region_offset,
  output logic [2:0]       region_prot,
  output logic             region_shared,
  output logic             range_empty,
  output logic [4:0]       region_slot
);

  localparam int IDXW = $clog2(MAX_REGIONS);
  localparam int CW   = $clog2(MAX_REGIONS + 1);
  localparam int AW   = IDXW + 1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RD    = 7'b0000010,
    S_EV    = 7'b0000100,
    S_GTAIL = 7'b0001000,
    S_EMIT  = 7'b0010000,
    S_RTAIL = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  typedef enum logic [1:0] {
    PH_GAP   = 2'd0,
    PH_REB   = 2'd1,
    PH_LOOK  = 2'd2,
    PH_EMPTY = 2'd3
  } phase_t;

  state_t state;
  phase_t phase;

  logic [20:0]   user_low;
  logic [20:0]   user_high;
  logic          sel;
  logic [CW-1:0] total;
  logic [CW-1:0] idx;
  logic [CW-1:0] cnt;
  logic          placed;
  logic          over;

  logic [2:0]  q_cmd;
  logic [20:0] q_first;
  logic [20:0] q_count;
  logic        q_dir;
  entry_t      nw;
  logic [21:0] lo;
  logic [21:0] hi;
  logic [20:0] cur;

  entry_t     pc0;
  entry_t     pc1;
  logic [1:0] pv;

  logic [1:0]  r_status;
  logic [20:0] r_page;
  logic [20:0] r_end;
  logic [19:0] r_off;
  logic [2:0]  r_prot;
  logic        r_sh;
  logic        r_empty;
  logic [4:0]  r_slot;

  // memory port
  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [AW-1:0] raddr;
  entry_t        d;

  prt_store #(.AW(AW)) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(d)
  );

  logic          scan_dn;
  logic          scan_done;
  logic [CW-1:0] rd_idx;

  assign scan_dn   = (phase == PH_GAP) && q_dir;
  assign scan_done = scan_dn ? (idx == '0) : (idx == total);
  assign rd_idx    = scan_dn ? idx - CW'(1) : idx;
  assign re        = (state == S_RD) && !scan_done;
  assign raddr     = {sel, rd_idx[IDXW-1:0]};

  // shared gap compare: dir 0 tests start >= cur + n, dir 1 tests cur >= end + n
  logic        tail;
  logic [21:0] gsum;
  logic [21:0] gref;
  logic        gap_hit;
  logic [20:0] gap_at;
  logic [21:0] at_end;

  assign tail = (state == S_GTAIL);
  always_comb begin
    if (q_dir) begin
      gsum = {1'b0, (tail ? user_low : d.end_pg)} + {1'b0, q_count};
      gref = {1'b0, cur};
    end else begin
      gsum = {1'b0, cur} + {1'b0, q_count};
      gref = {1'b0, (tail ? user_high : d.start_pg)};
    end
  end
  assign gap_hit = gref >= gsum;
  assign gap_at  = q_dir ? cur - q_count : cur;
  assign at_end  = {1'b0, gap_at} + {1'b0, q_count};

  // emit step of the rebuild
  entry_t cur_piece;
  logic   place_new;
  logic   full;
  logic   put;

  assign cur_piece = pv[0] ? pc0 : pc1;
  assign place_new = !placed && (state == S_RTAIL ||
                     ({1'b0, cur_piece.start_pg} >= hi));
  assign full  = (cnt >= CW'(MAX_REGIONS));
  assign put   = ((state == S_EMIT) && (pv != 2'b00)) || ((state == S_RTAIL) && !placed);
  assign we    = put && !full;
  assign waddr = {~sel, cnt[IDXW-1:0]};
  assign wdata = place_new ? nw : cur_piece;

  // overlap of the read entry with [lo, hi)
  logic ovl;
  assign ovl = ({1'b0, d.start_pg} < hi) && (lo < {1'b0, d.end_pg});

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= PH_GAP;
      user_low  <= 21'd1024;
      user_high <= 21'd786432;
      sel       <= 1'b0;
      total     <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
      cnt       <= '0;
      placed    <= 1'b1;
      over      <= 1'b0;
      pv        <= 2'b00;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LOW:  user_low  <= cfg_data;
          CFG_HIGH: user_high <= cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            q_cmd     <= cmd;
            q_first   <= first_page;
            q_count   <= page_count;
            q_dir     <= direction;
            nw.offset <= offset_page;
            nw.prot   <= protection;
            nw.shared <= shared;
            r_status  <= ST_OK;
            r_page    <= '0;
            r_end     <= '0;
            r_off     <= '0;
            r_prot    <= '0;
            r_sh      <= 1'b0;
            r_empty   <= 1'b0;
            r_slot    <= '0;
            lo        <= {1'b0, first_page};
            hi        <= {1'b0, first_page} + {1'b0, page_count};
            nw.start_pg <= first_page;
            nw.end_pg   <= first_page + page_count;
            cnt       <= '0;
            over      <= 1'b0;
            pv        <= 2'b00;
            state     <= S_OUT;
            case (cmd)
              CMD_MAP, CMD_FIND: begin
                if (page_count == '0) begin
                  r_status <= ST_NO_RANGE;
                end else if (cmd == CMD_FIND || first_page == '0) begin
                  phase <= PH_GAP;
                  cur   <= direction ? user_high : user_low;
                  idx   <= direction ? total : '0;
                  state <= S_RD;
                end else if (first_page < user_low ||
                             ({1'b0, first_page} + {1'b0, page_count}) >
                             {1'b0, user_high}) begin
                  r_status <= ST_NO_RANGE;
                end else begin
                  phase  <= PH_REB;
                  idx    <= '0;
                  placed <= 1'b0;
                  state  <= S_RD;
                end
              end
              CMD_UNMAP: begin
                if (page_count != '0) begin
                  phase  <= PH_REB;
                  idx    <= '0;
                  placed <= 1'b1;
                  state  <= S_RD;
                end
              end
              CMD_LOOKUP: begin
                phase <= PH_LOOK;
                idx   <= '0;
                state <= S_RD;
              end
              CMD_EMPTY: begin
                if (page_count == '0) begin
                  r_empty <= 1'b1;
                end else begin
                  phase <= PH_EMPTY;
                  idx   <= '0;
                  state <= S_RD;
                end
              end
              CMD_CLEAR: total <= '0;
              default: ;
            endcase
          end
        end

        S_RD: begin
          if (scan_done) begin
            case (phase)
              PH_GAP:  state <= S_GTAIL;
              PH_REB:  state <= S_RTAIL;
              PH_LOOK: begin
                r_status <= ST_NO_FOUND;
                state    <= S_OUT;
              end
              default: begin
                r_empty <= 1'b1;
                state   <= S_OUT;
              end
            endcase
          end else begin
            state <= S_EV;
          end
        end

        S_EV: begin
          case (phase)
            PH_GAP: begin
              if (gap_hit) begin
                if (q_cmd == CMD_MAP) begin
                  lo          <= {1'b0, gap_at};
                  hi          <= at_end;
                  nw.start_pg <= gap_at;
                  nw.end_pg   <= at_end[20:0];
                  phase       <= PH_REB;
                  idx         <= '0;
                  placed      <= 1'b0;
                  state       <= S_RD;
                end else begin
                  r_page <= gap_at;
                  r_end  <= at_end[20:0];
                  state  <= S_OUT;
                end
              end else begin
                if (q_dir) begin
                  if (d.start_pg < cur) cur <= d.start_pg;
                  idx <= idx - CW'(1);
                end else begin
                  if (d.end_pg > cur) cur <= d.end_pg;
                  idx <= idx + CW'(1);
                end
                state <= S_RD;
              end
            end
            PH_REB: begin
              if (ovl) begin
                pc0.start_pg <= d.start_pg;
                pc0.end_pg   <= lo[20:0];
                pc0.offset   <= d.offset;
                pc0.prot     <= d.prot;
                pc0.shared   <= d.shared;
                pc1.start_pg <= hi[20:0];
                pc1.end_pg   <= d.end_pg;
                pc1.offset   <= d.offset + hi[19:0] - d.start_pg[19:0];
                pc1.prot     <= d.prot;
                pc1.shared   <= d.shared;
                pv <= {(hi < {1'b0, d.end_pg}), ({1'b0, d.start_pg} < lo)};
              end else begin
                pc0 <= d;
                pv  <= 2'b01;
              end
              state <= S_EMIT;
            end
            PH_LOOK: begin
              if (q_first >= d.start_pg && q_first < d.end_pg) begin
                r_page <= d.start_pg;
                r_end  <= d.end_pg;
                r_off  <= d.offset;
                r_prot <= d.prot;
                r_sh   <= d.shared;
                r_slot <= 5'(idx);
                state  <= S_OUT;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
            default: begin
              if (ovl) begin
                r_empty <= 1'b0;
                state   <= S_OUT;
              end else begin
                idx   <= idx + CW'(1);
                state <= S_RD;
              end
            end
          endcase
        end

        S_GTAIL: begin
          // last gap, between the final entry scanned and the far bound
          if (gap_hit) begin
            if (q_cmd == CMD_MAP) begin
              lo          <= {1'b0, gap_at};
              hi          <= at_end;
              nw.start_pg <= gap_at;
              nw.end_pg   <= at_end[20:0];
              phase       <= PH_REB;
              idx         <= '0;
              placed      <= 1'b0;
              state       <= S_RD;
            end else begin
              r_page <= gap_at;
              r_end  <= at_end[20:0];
              state  <= S_OUT;
            end
          end else begin
            r_status <= ST_NO_RANGE;
            state    <= S_OUT;
          end
        end

        S_EMIT: begin
          if (pv == 2'b00) begin
            idx   <= idx + CW'(1);
            state <= S_RD;
          end else if (place_new) begin
            placed <= 1'b1;
            r_slot <= 5'(cnt);
          end else if (pv[0]) begin
            pv[0] <= 1'b0;
          end else begin
            pv[1] <= 1'b0;
          end
          if (put) begin
            if (full) over <= 1'b1;
            else cnt <= cnt + CW'(1);
          end
        end

        S_RTAIL: begin
          if (!placed) begin
            placed <= 1'b1;
            r_slot <= 5'(cnt);
            if (full) over <= 1'b1;
            else cnt <= cnt + CW'(1);
          end else begin
            if (over) begin
              r_status <= ST_FULL;
              r_slot   <= '0;
            end else begin
              sel   <= ~sel;
              total <= cnt;
              if (q_cmd == CMD_MAP) begin
                r_page <= nw.start_pg;
                r_end  <= nw.end_pg;
                r_off  <= nw.offset;
                r_prot <= nw.prot;
                r_sh   <= nw.shared;
              end
            end
            state <= S_OUT;
          end
        end

        S_OUT: begin
          if (!out_valid || out_ready) begin
            status        <= r_status;
            result_page   <= r_page;
            region_end    <= r_end;
            region_offset <= r_off;
            region_prot   <= r_prot;
            region_shared <= r_sh;
            range_empty   <= r_empty;
            region_slot   <= r_slot;
            out_valid     <= 1'b1;
            state         <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
